@@ hw/rtl/monitor_id_ddc_i2c_slave_assert.svh @@
// assertion helpers for the monitor id responder
`ifndef MONITOR_ID_DDC_I2C_SLAVE_ASSERT_SVH
`define MONITOR_ID_DDC_I2C_SLAVE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define MID_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define MID_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mon_id_pkg.sv @@
`timescale 1ns / 1ps

package mon_id_pkg;

    typedef enum logic [2:0] {
        PH_STOP = 3'd0,
        PH_DEV  = 3'd1,
        PH_REG  = 3'd2,
        PH_DATA = 3'd3,
        PH_ACK  = 3'd4
    } phase_t;

    // configuration register indexes
    localparam logic [1:0] CFG_ID_MODE   = 2'd0;
    localparam logic [1:0] CFG_STD_SENSE = 2'd1;
    localparam logic [1:0] CFG_EXT_SENSE = 2'd2;

    localparam logic       FUNC_PIN   = 1'b0;
    localparam logic       FUNC_STORE = 1'b1;

    localparam logic       MODE_DDC   = 1'b0;

    // {dirs, levels} patterns with one line pulled low
    localparam logic [5:0] SENSE_KEY_HI  = 6'h23;
    localparam logic [5:0] SENSE_KEY_MID = 6'h15;
    localparam logic [5:0] SENSE_KEY_LO  = 6'h0E;

    localparam logic [2:0] STD_SENSE_RST = 3'd6;
    localparam logic [5:0] EXT_SENSE_RST = 6'h2B;

    // 0xA0 with the direction bit dropped (shifted right by one)
    localparam logic [6:0] EDID_SLAVE_ID = 7'h50;

endpackage

@@ hw/rtl/monitor_id_ddc_i2c_slave.sv @@
`timescale 1ns / 1ps
// m_read_levels is registered: a result is loaded into it when its input beat is taken
// throughput: one beat per cycle unless m_ready stalls the output; the edid store is a
//   single-port-read memory; its registered read feeds the next beat, so no beat waits
// reset: aresetn (synchronous, active low) returns the bus slave to the stop phase and
//   the config registers to their defaults; the edid store is not cleared
module monitor_id_ddc_i2c_slave #(
    parameter int EDID_BYTES = 128
) (
    input  logic       aclk,
    input  logic       aresetn,

    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_wdata,

    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_func,
    input  logic [2:0] s_pin_levels,
    input  logic [2:0] s_pin_dirs,
    input  logic [6:0] s_store_index,
    input  logic [7:0] s_store_byte,

    output logic       m_valid,
    input  logic       m_ready,
    output logic [2:0] m_read_levels
);

    localparam int ADDR_W = $clog2(EDID_BYTES);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(EDID_BYTES - 1);

    // config
    logic       id_mode_reg;
    logic [2:0] std_sense_reg;
    logic [5:0] ext_sense_reg;

    // bus slave state
    mon_id_pkg::phase_t phase_reg, phase_next;
    mon_id_pkg::phase_t pba_reg, pba_next;
    logic              prev_sda_reg, prev_sda_next;
    logic              prev_scl_reg, prev_scl_next;
    logic [2:0]        bit_reg, bit_next;
    logic [7:0]        shift_reg, shift_next;
    logic [7:0]        dev_byte_reg, dev_byte_next;
    logic [7:0]        reg_byte_reg, reg_byte_next;
    logic [ADDR_W-1:0] rptr_reg, rptr_next;
    logic              pend_reg, pend_next;

    logic              m_valid_reg;
    logic [2:0]        m_levels_reg, m_levels_next;

    // edid store
    logic [7:0]        edid_mem [EDID_BYTES];
    logic [7:0]        rdata_reg;
    logic [ADDR_W-1:0] raddr;
    logic              fetch;

    logic              accept;
    logic              scl, sda, sda_o, rose;
    logic [7:0]        shift_cur, shift_in;
    logic [5:0]        sense_key;
    logic [2:0]        sense_code;

    assign s_ready       = !m_valid_reg || m_ready;
    assign accept        = s_valid && s_ready;
    assign m_valid       = m_valid_reg;
    assign m_read_levels = m_levels_reg;

    // a byte fetched on the last accepted beat is registered and lands here on the next beat
    assign shift_cur = pend_reg ? rdata_reg : shift_reg;

    assign scl  = s_pin_dirs[1] ? s_pin_levels[1] : 1'b1;
    assign sda  = s_pin_dirs[2] ? s_pin_levels[2] : 1'b1;
    assign rose = scl && !prev_scl_reg;
    assign shift_in = {shift_cur[6:0], sda};

    assign sense_key = {s_pin_dirs, s_pin_levels};

    always_comb begin
        case (sense_key)
            mon_id_pkg::SENSE_KEY_HI:  sense_code = {1'b0, ext_sense_reg[5:4]};
            mon_id_pkg::SENSE_KEY_MID: sense_code = {ext_sense_reg[3], 1'b0, ext_sense_reg[2]};
            mon_id_pkg::SENSE_KEY_LO:  sense_code = {ext_sense_reg[1:0], 1'b0};
            default:                   sense_code = std_sense_reg;
        endcase
    end

    always_comb begin
        phase_next    = phase_reg;
        pba_next      = pba_reg;
        prev_sda_next = prev_sda_reg;
        prev_scl_next = prev_scl_reg;
        bit_next      = bit_reg;
        shift_next    = shift_cur;
        dev_byte_next = dev_byte_reg;
        reg_byte_next = reg_byte_reg;
        rptr_next     = rptr_reg;
        fetch         = 1'b0;
        raddr         = rptr_reg;
        sda_o         = sda;
        m_levels_next = 3'd0;

        if (s_func == mon_id_pkg::FUNC_PIN) begin
            if (id_mode_reg != mon_id_pkg::MODE_DDC) begin
                m_levels_next = sense_code;
            end else begin
                if (sda != prev_sda_reg) begin
                    // sda edge with scl high is start or stop
                    if (scl) begin
                        if (!sda) begin
                            phase_next = mon_id_pkg::PH_DEV;
                            bit_next   = 3'd0;
                        end else begin
                            phase_next = mon_id_pkg::PH_STOP;
                        end
                    end
                end else if (rose) begin
                    case (phase_reg)
                        mon_id_pkg::PH_ACK: begin
                            bit_next   = 3'd0;
                            shift_next = 8'd0;
                            case (pba_reg)
                                mon_id_pkg::PH_DEV: begin
                                    sda_o = (dev_byte_reg[7:1] == mon_id_pkg::EDID_SLAVE_ID)
                                            ? 1'b0 : 1'b1;
                                    if (dev_byte_reg[0]) begin
                                        phase_next = mon_id_pkg::PH_DATA;
                                        fetch      = 1'b1;
                                        raddr      = '0;
                                        rptr_next  = ADDR_W'(1);
                                    end else begin
                                        phase_next = mon_id_pkg::PH_REG;
                                    end
                                end
                                mon_id_pkg::PH_REG: begin
                                    phase_next = mon_id_pkg::PH_DATA;
                                    sda_o      = (reg_byte_reg == 8'd0) ? 1'b0 : 1'b1;
                                end
                                mon_id_pkg::PH_DATA: begin
                                    phase_next = mon_id_pkg::PH_DATA;
                                    if (dev_byte_reg[0]) begin
                                        // master ack loads the next byte
                                        if (!sda) begin
                                            fetch     = 1'b1;
                                            rptr_next = (rptr_reg == LAST_ADDR)
                                                        ? '0 : rptr_reg + ADDR_W'(1);
                                        end
                                    end else begin
                                        sda_o = 1'b0;
                                    end
                                end
                                default: begin
                                end
                            endcase
                        end
                        mon_id_pkg::PH_DEV, mon_id_pkg::PH_REG: begin
                            shift_next = shift_in;
                            if (bit_reg == 3'd7) begin
                                bit_next   = 3'd0;
                                pba_next   = phase_reg;
                                phase_next = mon_id_pkg::PH_ACK;
                                if (phase_reg == mon_id_pkg::PH_DEV) begin
                                    dev_byte_next = shift_in;
                                end else begin
                                    reg_byte_next = shift_in;
                                end
                            end else begin
                                bit_next = bit_reg + 3'd1;
                            end
                        end
                        mon_id_pkg::PH_DATA: begin
                            if (dev_byte_reg[0]) begin
                                sda_o = shift_cur[3'd7 - bit_reg];
                            end else begin
                                shift_next = shift_in;
                            end
                            if (bit_reg == 3'd7) begin
                                bit_next   = 3'd0;
                                pba_next   = mon_id_pkg::PH_DATA;
                                phase_next = mon_id_pkg::PH_ACK;
                            end else begin
                                bit_next = bit_reg + 3'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                prev_sda_next = sda_o;
                prev_scl_next = scl;
                m_levels_next = {sda_o, scl, 1'b0};
            end
        end
    end

    assign pend_next = fetch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            id_mode_reg   <= 1'b0;
            std_sense_reg <= mon_id_pkg::STD_SENSE_RST;
            ext_sense_reg <= mon_id_pkg::EXT_SENSE_RST;
            phase_reg     <= mon_id_pkg::PH_STOP;
            pba_reg       <= mon_id_pkg::PH_STOP;
            prev_sda_reg  <= 1'b1;
            prev_scl_reg  <= 1'b1;
            bit_reg       <= 3'd0;
            shift_reg     <= 8'd0;
            dev_byte_reg  <= 8'd0;
            reg_byte_reg  <= 8'd0;
            rptr_reg      <= '0;
            pend_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    mon_id_pkg::CFG_ID_MODE:   id_mode_reg   <= cfg_wdata[0];
                    mon_id_pkg::CFG_STD_SENSE: std_sense_reg <= cfg_wdata[2:0];
                    mon_id_pkg::CFG_EXT_SENSE: ext_sense_reg <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                phase_reg    <= phase_next;
                pba_reg      <= pba_next;
                prev_sda_reg <= prev_sda_next;
                prev_scl_reg <= prev_scl_next;
                bit_reg      <= bit_next;
                shift_reg    <= shift_next;
                dev_byte_reg <= dev_byte_next;
                reg_byte_reg <= reg_byte_next;
                rptr_reg     <= rptr_next;
                pend_reg     <= pend_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_levels_reg <= m_levels_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && s_func == mon_id_pkg::FUNC_STORE) begin
            edid_mem[ADDR_W'(s_store_index)] <= s_store_byte;
        end
        if (accept && fetch) begin
            rdata_reg <= edid_mem[raddr];
        end
    end

`include "monitor_id_ddc_i2c_slave_assert.svh"

    `MID_ASSERT_NOW(a_ack_has_origin, phase_reg == mon_id_pkg::PH_ACK,
        pba_reg == mon_id_pkg::PH_DEV || pba_reg == mon_id_pkg::PH_REG ||
        pba_reg == mon_id_pkg::PH_DATA, "ack phase without a byte phase before it")
    `MID_ASSERT_NOW(a_pend_in_read, pend_reg,
        phase_reg == mon_id_pkg::PH_DATA && dev_byte_reg[0],
        "fetched byte pending outside a read transfer")
    `MID_ASSERT_NEXT(a_store_result, accept && s_func == mon_id_pkg::FUNC_STORE,
        m_valid && m_read_levels == 3'd0, "store write beat did not return zero")
    `MID_ASSERT_NEXT(a_beat_result, accept, m_valid, "accepted beat produced no result")

endmodule
